>>> rtl/prrs_pkg.sv
// shared types and constants of the priority round-robin scheduler
package prrs_pkg;

    localparam int NUM_TASKS  = 16;
    localparam int NUM_LEVELS = 8;
    localparam int TASK_W     = $clog2(NUM_TASKS);
    localparam int LVL_W      = $clog2(NUM_LEVELS);

    // command codes
    localparam logic [1:0] CMD_ACTIVATE = 2'd0;
    localparam logic [1:0] CMD_SUSPEND  = 2'd1;
    localparam logic [1:0] CMD_TICK     = 2'd2;

    // status codes
    localparam logic ST_DONE    = 1'b0;
    localparam logic ST_IGNORED = 1'b1;

    typedef logic [TASK_W-1:0] task_t;
    typedef logic [LVL_W-1:0]  level_t;

    // one task entry of the link file
    typedef struct packed {
        task_t  next;
        task_t  prev;
        level_t lvl;
    } link_t;

    // one write per field per cycle
    typedef struct packed {
        logic   next_we;
        task_t  next_addr;
        task_t  next_data;
        logic   prev_we;
        task_t  prev_addr;
        task_t  prev_data;
        logic   lvl_we;
        task_t  lvl_addr;
        level_t lvl_data;
    } link_wr_t;

    // answer of the level search unit
    typedef struct packed {
        logic   done;
        logic   found;
        level_t level;
    } scan_rsp_t;

endpackage

>>> rtl/prrs_link_file.sv
// per-task ring links and level, one shared read address and one write per field
module prrs_link_file
    import prrs_pkg::*;
(
    input  logic     aclk,
    input  task_t    raddr,
    output link_t    rdata,
    input  link_wr_t wr
);

    task_t  next_mem [NUM_TASKS];
    task_t  prev_mem [NUM_TASKS];
    level_t lvl_mem  [NUM_TASKS];

    // field writes
    always_ff @(posedge aclk) begin
        if (wr.next_we) begin
            next_mem[wr.next_addr] <= wr.next_data;
        end
        if (wr.prev_we) begin
            prev_mem[wr.prev_addr] <= wr.prev_data;
        end
        if (wr.lvl_we) begin
            lvl_mem[wr.lvl_addr] <= wr.lvl_data;
        end
    end

    // single read port
    assign rdata.next = next_mem[raddr];
    assign rdata.prev = prev_mem[raddr];
    assign rdata.lvl  = lvl_mem[raddr];

endmodule

>>> rtl/prrs_level_scan.sv
// iterative search for the highest non-empty level below a start level
module prrs_level_scan
    import prrs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  level_t                from_level,
    input  logic [NUM_LEVELS-1:0] nonempty,
    output scan_rsp_t             rsp
);

    logic   busy_reg, busy_next;
    level_t idx_reg, idx_next;
    level_t below;
    logic   at_bottom;
    logic   hit;

    // one level tested per cycle
    assign at_bottom = (idx_reg == '0);
    assign below     = idx_reg - level_t'(1);
    assign hit       = !at_bottom && nonempty[below];

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (start) begin
            busy_next = 1'b1;
            idx_next  = from_level;
        end else if (busy_reg) begin
            if (at_bottom || hit) begin
                busy_next = 1'b0;
            end else begin
                idx_next = below;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        idx_reg <= idx_next;
    end

    assign rsp.done  = busy_reg && (at_bottom || hit);
    assign rsp.found = hit;
    assign rsp.level = below;

endmodule

>>> rtl/priority_round_robin_scheduler_top.sv
// Multilevel priority round-robin scheduler: one circular ready ring per level, higher
// level wins, timer ticks rotate the running level's ring. Each input word gives one
// result word. Words are handled one at a time by a small sequencer over a single-read
// link file. From acceptance an item passes S_START and S_FIN when it is ignored, a tick,
// an activation into an empty level, or a suspend that empties a level other than the
// running one. A suspend that leaves other tasks in its ring adds S_SUS1, and an
// activation appended to a non-empty ring adds S_ACT1 and S_ACT2. A suspend that empties
// the running level adds S_SCAN, where the level search unit walks down one level per
// cycle (at most NUM_LEVELS steps). A finished result sits in the output register; the
// block goes on only once it is free.
module priority_round_robin_scheduler_top
    import prrs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // command[1:0], task_id[5:2], priority_req[8:6], zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // current_task[3:0], idle[4], switched[5], status[6], zero
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_ACT1  = 3'd2;
    localparam logic [2:0] S_ACT2  = 3'd3;
    localparam logic [2:0] S_SUS1  = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [1:0]            cmd_reg, cmd_next;
    task_t                 tid_reg, tid_next;
    level_t                pri_reg, pri_next;
    logic                  st_reg, st_next;
    logic                  was_idle_reg, was_idle_next;
    task_t                 was_task_reg, was_task_next;
    task_t                 h_reg, h_next;
    task_t                 tail_reg, tail_next;
    task_t                 nx_reg, nx_next;
    task_t                 pv_reg, pv_next;
    level_t                lv_reg, lv_next;
    logic [NUM_TASKS-1:0]  queued_reg, queued_next;
    logic [NUM_LEVELS-1:0] nonempty_reg, nonempty_next;
    level_t                cur_reg, cur_next;
    logic                  idle_reg, idle_next;
    logic                  m_valid_reg, m_valid_next;
    logic [7:0]            m_data_reg, m_data_next;

    task_t                 head_reg [NUM_LEVELS];
    logic                  head_we;
    level_t                head_waddr;
    task_t                 head_wdata;
    level_t                head_raddr;
    task_t                 head_rd;

    task_t                 link_raddr;
    link_t                 link_rd;
    link_wr_t              link_wr;

    logic                  scan_start;
    scan_rsp_t             scan_rsp;

    task_t                 now_task;
    logic                  sw;

    prrs_link_file u_link (
        .aclk  (aclk),
        .raddr (link_raddr),
        .rdata (link_rd),
        .wr    (link_wr)
    );

    prrs_level_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (scan_start),
        .from_level (lv_next),
        .nonempty   (nonempty_reg),
        .rsp        (scan_rsp)
    );

    // ring head read port
    always_comb begin
        case (state_reg)
            S_ACT1:  head_raddr = pri_reg;
            S_SUS1:  head_raddr = lv_reg;
            default: head_raddr = cur_reg;
        endcase
    end
    assign head_rd = head_reg[head_raddr];

    // link file reads the suspended task, else the selected head
    assign link_raddr = (state_reg == S_START && cmd_reg == CMD_SUSPEND) ? tid_reg : head_rd;

    // result word fields
    assign now_task = idle_reg ? '0 : head_rd;
    assign sw = (was_idle_reg != idle_reg) || (!idle_reg && was_task_reg != now_task);

    // sequencer
    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        tid_next      = tid_reg;
        pri_next      = pri_reg;
        st_next       = st_reg;
        was_idle_next = was_idle_reg;
        was_task_next = was_task_reg;
        h_next        = h_reg;
        tail_next     = tail_reg;
        nx_next       = nx_reg;
        pv_next       = pv_reg;
        lv_next       = lv_reg;
        queued_next   = queued_reg;
        nonempty_next = nonempty_reg;
        cur_next      = cur_reg;
        idle_next     = idle_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        head_we       = 1'b0;
        head_waddr    = cur_reg;
        head_wdata    = head_rd;
        link_wr       = '0;
        scan_start    = 1'b0;
        s_tready      = 1'b0;

        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd_next   = s_tdata[1:0];
                    tid_next   = s_tdata[5:2];
                    pri_next   = s_tdata[8:6];
                    state_next = S_START;
                end
            end

            S_START: begin
                was_idle_next = idle_reg;
                was_task_next = idle_reg ? '0 : head_rd;
                st_next       = ST_DONE;
                state_next    = S_FIN;
                case (cmd_reg)
                    CMD_ACTIVATE: begin
                        if (queued_reg[tid_reg]) begin
                            st_next = ST_IGNORED;
                        end else if (!nonempty_reg[pri_reg]) begin
                            // first task of an empty level rings to itself
                            head_we                = 1'b1;
                            head_waddr             = pri_reg;
                            head_wdata             = tid_reg;
                            link_wr.next_we        = 1'b1;
                            link_wr.next_addr      = tid_reg;
                            link_wr.next_data      = tid_reg;
                            link_wr.prev_we        = 1'b1;
                            link_wr.prev_addr      = tid_reg;
                            link_wr.prev_data      = tid_reg;
                            link_wr.lvl_we         = 1'b1;
                            link_wr.lvl_addr       = tid_reg;
                            link_wr.lvl_data       = pri_reg;
                            nonempty_next[pri_reg] = 1'b1;
                            queued_next[tid_reg]   = 1'b1;
                            if (idle_reg || pri_reg > cur_reg) begin
                                cur_next = pri_reg;
                            end
                            idle_next = 1'b0;
                        end else begin
                            state_next = S_ACT1;
                        end
                    end
                    CMD_SUSPEND: begin
                        if (!queued_reg[tid_reg]) begin
                            st_next = ST_IGNORED;
                        end else begin
                            queued_next[tid_reg] = 1'b0;
                            lv_next = link_rd.lvl;
                            nx_next = link_rd.next;
                            pv_next = link_rd.prev;
                            if (link_rd.next == tid_reg) begin
                                // last task of its level
                                nonempty_next[link_rd.lvl] = 1'b0;
                                if (!idle_reg && link_rd.lvl == cur_reg) begin
                                    scan_start = 1'b1;
                                    state_next = S_SCAN;
                                end
                            end else begin
                                state_next = S_SUS1;
                            end
                        end
                    end
                    CMD_TICK: begin
                        if (!idle_reg) begin
                            head_we    = 1'b1;
                            head_waddr = cur_reg;
                            head_wdata = link_rd.next;
                        end
                    end
                    default: begin
                        st_next = ST_IGNORED;
                    end
                endcase
            end

            S_ACT1: begin
                // new task goes between tail and head
                h_next            = head_rd;
                tail_next         = link_rd.prev;
                link_wr.next_we   = 1'b1;
                link_wr.next_addr = tid_reg;
                link_wr.next_data = head_rd;
                link_wr.prev_we   = 1'b1;
                link_wr.prev_addr = tid_reg;
                link_wr.prev_data = link_rd.prev;
                link_wr.lvl_we    = 1'b1;
                link_wr.lvl_addr  = tid_reg;
                link_wr.lvl_data  = pri_reg;
                state_next        = S_ACT2;
            end

            S_ACT2: begin
                link_wr.next_we      = 1'b1;
                link_wr.next_addr    = tail_reg;
                link_wr.next_data    = tid_reg;
                link_wr.prev_we      = 1'b1;
                link_wr.prev_addr    = h_reg;
                link_wr.prev_data    = tid_reg;
                queued_next[tid_reg] = 1'b1;
                if (idle_reg || pri_reg > cur_reg) begin
                    cur_next = pri_reg;
                end
                idle_next  = 1'b0;
                state_next = S_FIN;
            end

            S_SUS1: begin
                // unlink, and move the head on if it was the removed task
                if (head_rd == tid_reg) begin
                    head_we    = 1'b1;
                    head_waddr = lv_reg;
                    head_wdata = nx_reg;
                end
                link_wr.next_we   = 1'b1;
                link_wr.next_addr = pv_reg;
                link_wr.next_data = nx_reg;
                link_wr.prev_we   = 1'b1;
                link_wr.prev_addr = nx_reg;
                link_wr.prev_data = pv_reg;
                state_next        = S_FIN;
            end

            S_SCAN: begin
                if (scan_rsp.done) begin
                    if (scan_rsp.found) begin
                        cur_next = scan_rsp.level;
                    end else begin
                        idle_next = 1'b1;
                    end
                    state_next = S_FIN;
                end
            end

            S_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, st_reg, sw, idle_reg, now_task};
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and payload registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            queued_reg   <= '0;
            nonempty_reg <= '0;
            cur_reg      <= '0;
            idle_reg     <= 1'b1;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            queued_reg   <= queued_next;
            nonempty_reg <= nonempty_next;
            cur_reg      <= cur_next;
            idle_reg     <= idle_next;
            m_valid_reg  <= m_valid_next;
        end
        cmd_reg      <= cmd_next;
        tid_reg      <= tid_next;
        pri_reg      <= pri_next;
        st_reg       <= st_next;
        was_idle_reg <= was_idle_next;
        was_task_reg <= was_task_next;
        h_reg        <= h_next;
        tail_reg     <= tail_next;
        nx_reg       <= nx_next;
        pv_reg       <= pv_next;
        lv_reg       <= lv_next;
        m_data_reg   <= m_data_next;
    end

    // ring heads
    always_ff @(posedge aclk) begin
        if (head_we) begin
            head_reg[head_waddr] <= head_wdata;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> rtl/prrs_checker.sv
// port-level checks of the scheduler, bound to the top level
module prrs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    // an accepted word keeps the input closed for the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after acceptance");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // idle reports task zero
    a_idle_task: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> m_tdata[3:0] == 4'd0)
        else $error("idle result with a non-zero task");

    // an ignored command never switches
    a_ignored_no_switch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[6] |-> !m_tdata[5])
        else $error("ignored command reported a switch");

    // nothing leaves straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind priority_round_robin_scheduler_top prrs_checker u_prrs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/sv/testbench.sv
// testbench of the priority round-robin scheduler: scoreboard class, stream drivers, checks

// one expected or observed result word, field by field
typedef struct packed {
    prrs_pkg::task_t running;
    logic            idle;
    logic            switched;
    logic            status;
} sched_out_t;

// scheduler predictor and store of expected result words
class sched_scoreboard;
    prrs_pkg::task_t                  succ     [prrs_pkg::NUM_TASKS];
    prrs_pkg::task_t                  pred     [prrs_pkg::NUM_TASKS];
    prrs_pkg::level_t                 level_of [prrs_pkg::NUM_TASKS];
    prrs_pkg::task_t                  head     [prrs_pkg::NUM_LEVELS];
    logic [prrs_pkg::NUM_TASKS-1:0]   queued;
    logic [prrs_pkg::NUM_LEVELS-1:0]  busy;
    prrs_pkg::level_t                 run_level;
    logic                             no_task;
    sched_out_t                       expected_q [$];
    int                               n_errors;

    // state just after reset
    function new();
        for (int i = 0; i < prrs_pkg::NUM_TASKS; i++) begin
            succ[i]     = '0;
            pred[i]     = '0;
            level_of[i] = '0;
        end
        for (int i = 0; i < prrs_pkg::NUM_LEVELS; i++) begin
            head[i] = '0;
        end
        queued    = '0;
        busy      = '0;
        run_level = '0;
        no_task   = 1'b1;
        n_errors  = 0;
    endfunction

    // append a task at the tail of its level's ring
    function logic activate(prrs_pkg::task_t t, prrs_pkg::level_t p);
        prrs_pkg::task_t h;
        prrs_pkg::task_t tl;
        if (queued[t]) return prrs_pkg::ST_IGNORED;
        if (!busy[p]) begin
            head[p] = t;
            succ[t] = t;
            pred[t] = t;
            busy[p] = 1'b1;
        end else begin
            h       = head[p];
            tl      = pred[h];
            succ[tl] = t;
            pred[t]  = tl;
            succ[t]  = h;
            pred[h]  = t;
        end
        level_of[t] = p;
        queued[t]   = 1'b1;
        if (no_task || p > run_level) run_level = p;
        no_task = 1'b0;
        return prrs_pkg::ST_DONE;
    endfunction

    // unlink a task; an emptied running level falls to the next busy one below
    function logic suspend(prrs_pkg::task_t t);
        prrs_pkg::level_t lv;
        prrs_pkg::task_t  nx;
        prrs_pkg::task_t  pv;
        logic             found;
        if (!queued[t]) return prrs_pkg::ST_IGNORED;
        lv        = level_of[t];
        nx        = succ[t];
        pv        = pred[t];
        queued[t] = 1'b0;
        if (nx == t) begin
            busy[lv] = 1'b0;
            if (!no_task && lv == run_level) begin
                found = 1'b0;
                for (int i = int'(lv) - 1; i >= 0; i--) begin
                    if (!found && busy[i]) begin
                        run_level = prrs_pkg::level_t'(i);
                        found     = 1'b1;
                    end
                end
                if (!found) no_task = 1'b1;
            end
            return prrs_pkg::ST_DONE;
        end
        if (head[lv] == t) head[lv] = nx;
        succ[pv] = nx;
        pred[nx] = pv;
        return prrs_pkg::ST_DONE;
    endfunction

    // accepted input word: step the predictor and queue the expected result
    function void note_input(logic [15:0] w);
        logic [1:0]       cmd;
        prrs_pkg::task_t  t;
        prrs_pkg::level_t p;
        logic             was_idle;
        prrs_pkg::task_t  was_task;
        sched_out_t       r;
        cmd      = w[1:0];
        t        = w[5:2];
        p        = w[8:6];
        was_idle = no_task;
        was_task = no_task ? '0 : head[run_level];
        case (cmd)
            prrs_pkg::CMD_ACTIVATE: r.status = activate(t, p);
            prrs_pkg::CMD_SUSPEND:  r.status = suspend(t);
            prrs_pkg::CMD_TICK: begin
                if (!no_task) head[run_level] = succ[head[run_level]];
                r.status = prrs_pkg::ST_DONE;
            end
            default: r.status = prrs_pkg::ST_IGNORED;
        endcase
        r.running  = no_task ? '0 : head[run_level];
        r.idle     = no_task;
        r.switched = (was_idle != no_task) || (!no_task && was_task != r.running);
        expected_q.push_back(r);
    endfunction

    task report(string what);
        n_errors++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    // accepted result word against the oldest expectation
    task check_result(logic [7:0] w);
        sched_out_t got;
        sched_out_t want;
        got.running  = w[3:0];
        got.idle     = w[4];
        got.switched = w[5];
        got.status   = w[6];
        if (expected_q.size() == 0) begin
            report($sformatf("result word 0x%02h with nothing expected", w));
            return;
        end
        want = expected_q.pop_front();
        if (got.running !== want.running)
            report($sformatf("current_task %0d, expected %0d", got.running, want.running));
        if (got.idle !== want.idle)
            report($sformatf("idle %0b, expected %0b", got.idle, want.idle));
        if (got.switched !== want.switched)
            report($sformatf("switched %0b, expected %0b", got.switched, want.switched));
        if (got.status !== want.status)
            report($sformatf("status %0b, expected %0b", got.status, want.status));
    endtask

    function int pending();
        return expected_q.size();
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import prrs_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         LONG_HOLD  = 300;

    typedef enum int {RX_FREE, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [7:0]  m_tdata;

    sched_scoreboard         sched_sb = new();
    bit                      hold_req = 1'b0;
    logic [NUM_TASKS-1:0]    offered  = '0;

    always #5 aclk = ~aclk;

    priority_round_robin_scheduler_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // word monitors on both channels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sched_sb.note_input(s_tdata);
            if (m_tvalid && m_tready) sched_sb.check_result(m_tdata);
        end
    end

    // receiver: stall pattern of its own, plus one long hold-off on request
    initial begin
        rx_mode_t mode;
        int       left;
        int       hold_left;
        mode      = RX_FREE;
        left      = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
                m_tready  <= 1'b0;
            end else begin
                if (left == 0) begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    left = $urandom_range(8, 80);
                end
                left--;
                case (mode)
                    RX_FREE:   m_tready <= 1'b1;
                    RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= (left % 5 != 0);
                endcase
            end
        end
    end

    // offer one word and hold it until taken
    task send_word(logic [1:0] cmd, task_t t, level_t p);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, p, t, cmd};
        do @(posedge aclk); while (!s_tready);
        if (cmd == CMD_ACTIVATE) offered[t] = 1'b1;
        if (cmd == CMD_SUSPEND)  offered[t] = 1'b0;
    endtask

    // stop offering and wait until every expected word has come back
    task drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sched_sb.pending() != 0);
    endtask

    // a task that is queued (want_set) or free, random if there is none
    function task_t pick_task(logic want_set);
        task_t cand [$];
        for (int i = 0; i < NUM_TASKS; i++) begin
            if (offered[i] == want_set) cand.push_back(task_t'(i));
        end
        if (cand.size() == 0) return task_t'($urandom_range(0, NUM_TASKS - 1));
        return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    // stimulus
    initial begin
        int         sent;
        int         burst;
        int         gap;
        int         act_pct;
        int         roll;
        logic [1:0] cmd;
        task_t      t;
        level_t     p;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: idle cases, raising, rotation, head removal, level fall-through
        send_word(CMD_TICK,     4'd0,  3'd0);   // tick while idle
        send_word(CMD_SUSPEND,  4'd6,  3'd0);   // suspend of a task not queued
        send_word(CMD_ACTIVATE, 4'd0,  3'd0);   // first task, lowest level
        send_word(CMD_ACTIVATE, 4'd15, 3'd7);   // raises to the top level
        send_word(CMD_ACTIVATE, 4'd15, 3'd2);   // already queued
        send_word(CMD_ACTIVATE, 4'd5,  3'd7);   // appended behind the head
        send_word(CMD_ACTIVATE, 4'd9,  3'd7);
        send_word(CMD_TICK,     4'd3,  3'd5);   // rotate the running ring
        send_word(CMD_TICK,     4'd0,  3'd0);
        send_word(CMD_TICK,     4'd0,  3'd0);
        send_word(CMD_SUSPEND,  4'd15, 3'd0);   // head leaves, next task takes over
        send_word(CMD_SUSPEND,  4'd9,  3'd0);   // non-head member leaves
        send_word(CMD_ACTIVATE, 4'd3,  3'd3);   // lower than the running level
        send_word(CMD_SUSPEND,  4'd5,  3'd0);   // top level empties, falls to level 3
        send_word(CMD_ACTIVATE, 4'd7,  3'd1);
        send_word(CMD_SUSPEND,  4'd0,  3'd0);   // level below the running one
        send_word(CMD_UNUSED,   4'd15, 3'd7);   // unknown command
        send_word(CMD_SUSPEND,  4'd3,  3'd0);   // falls past empty level 2 to level 1
        send_word(CMD_SUSPEND,  4'd7,  3'd0);   // last task leaves, idle again
        send_word(CMD_ACTIVATE, 4'd10, 3'd0);
        send_word(CMD_SUSPEND,  4'd10, 3'd7);   // idle from level zero
        send_word(CMD_TICK,     4'd15, 3'd7);
        drain();

        // random bursts; every word sent is counted
        sent = 0;
        while (sent < 1630) begin
            burst   = $urandom_range(1, 40);
            gap     = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            act_pct = $urandom_range(25, 65);
            for (int b = 0; b < burst; b++) begin
                roll = $urandom_range(0, 99);
                p    = level_t'($urandom_range(0, NUM_LEVELS - 1));
                if (roll < act_pct) begin
                    cmd = CMD_ACTIVATE;
                    t   = pick_task($urandom_range(0, 99) < 15);
                end else if (roll < act_pct + 30) begin
                    cmd = CMD_SUSPEND;
                    t   = pick_task($urandom_range(0, 99) < 85);
                end else if (roll < 97) begin
                    cmd = CMD_TICK;
                    t   = task_t'($urandom_range(0, NUM_TASKS - 1));
                end else begin
                    cmd = CMD_UNUSED;
                    t   = task_t'($urandom_range(0, NUM_TASKS - 1));
                end
                send_word(cmd, t, p);
                sent++;
                if (sent == 600) hold_req = 1'b1;
                if (sent == 1100) drain();
            end
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end

        drain();
        repeat (20) @(posedge aclk);
        if (sched_sb.n_errors == 0)
            $display("** priority_round_robin_scheduler_top: PASSED **");
        else
            $display("** priority_round_robin_scheduler_top: FAILED **");
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("** priority_round_robin_scheduler_top: FAILED **");
        $finish;
    end
endmodule

>>> files.f
rtl/prrs_pkg.sv
rtl/prrs_link_file.sv
rtl/prrs_level_scan.sv
rtl/priority_round_robin_scheduler_top.sv
rtl/prrs_checker.sv
tb/sv/testbench.sv
